### rtl/fqd_pkg.sv
// ----------------------------------------------------------------------------
// fqd_pkg
// Shared types, character constants and helpers for the form query decoder.
// ----------------------------------------------------------------------------
package fqd_pkg;

    localparam int unsigned MaxResults = 4;
    localparam int unsigned CountW     = $clog2(MaxResults + 1);
    localparam int unsigned IdxW       = $clog2(MaxResults);

    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] HEX_TEN  = 8'd10;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic       in_value_part;
        logic       name_end;
        logic       pair_end;
        logic       query_end;
    } res_t;

    function automatic logic is_hex(input logic [7:0] ch);
        return (ch >= CH_0 && ch <= CH_9) || (ch >= CH_LA && ch <= CH_LF) ||
               (ch >= CH_UA && ch <= CH_UF);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] ch);
        logic [7:0] v;
        if (ch >= CH_0 && ch <= CH_9) begin
            v = ch - CH_0;
        end else if (ch >= CH_LA && ch <= CH_LF) begin
            v = ch - CH_LA + HEX_TEN;
        end else begin
            v = ch - CH_UA + HEX_TEN;
        end
        return v[3:0];
    endfunction

    function automatic res_t mk_data(input logic [7:0] b, input logic side);
        res_t r;
        r.data_byte     = b;
        r.has_data      = 1'b1;
        r.in_value_part = side;
        r.name_end      = 1'b0;
        r.pair_end      = 1'b0;
        r.query_end     = 1'b0;
        return r;
    endfunction

    function automatic res_t mk_mark(input logic side, input logic ne,
                                     input logic pe, input logic qe);
        res_t r;
        r.data_byte     = CH_NUL;
        r.has_data      = 1'b0;
        r.in_value_part = side;
        r.name_end      = ne;
        r.pair_end      = pe;
        r.query_end     = qe;
        return r;
    endfunction

endpackage

### rtl/form_query_decoder_core.sv
// ----------------------------------------------------------------------------
// form_query_decoder_core
// Results appear, registered, in the cycle after their request is accepted.
// Throughput: one request per cycle while m_ready is high and each causes at
// most one result; with k results, s_ready stays low until the last is taken.
// Reset (aresetn low, synchronous): escape, name/value and pair state clear,
// result buffer empties; no clearing pass.
// ----------------------------------------------------------------------------
module form_query_decoder_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_query_byte,
    input  logic       s_final_req,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic       m_has_data,
    output logic       m_in_value_part,
    output logic       m_name_end,
    output logic       m_pair_end,
    output logic       m_query_end,
    output logic       m_last
);
    import fqd_pkg::*;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_PCT,
        ESC_DIGIT
    } esc_t;

    esc_t              esc_reg, esc_next;
    logic [7:0]        held_reg, held_next;
    logic              vs_reg, vs_next;
    logic              po_reg, po_next;
    res_t              slot_reg  [MaxResults];
    res_t              slot_next [MaxResults];
    logic [CountW-1:0] cnt_reg, cnt_next;
    logic [IdxW-1:0]   idx_reg;
    logic              s_fire, m_fire, at_last;
    res_t              cur;

    always_comb begin
        esc_t              ph;
        logic              vs;
        logic              po;
        logic [7:0]        hd;
        logic [CountW-1:0] n;
        logic              do_plain;
        logic              in_hex;
        logic [7:0]        b;
        ph       = esc_reg;
        vs       = vs_reg;
        po       = po_reg;
        hd       = held_reg;
        n        = '0;
        do_plain = 1'b0;
        b        = s_query_byte;
        in_hex   = is_hex(b);
        for (int i = 0; i < MaxResults; i++) begin
            slot_next[i] = slot_reg[i];
        end
        if (b != CH_NUL) begin
            case (esc_reg)
                ESC_PCT: begin
                    if (in_hex) begin
                        hd = b;
                        ph = ESC_DIGIT;
                    end else begin
                        ph = ESC_NONE;
                        slot_next[n[IdxW-1:0]] = mk_data(CH_PCT, vs);
                        n = n + CountW'(1);
                        do_plain = 1'b1;
                    end
                end
                ESC_DIGIT: begin
                    ph = ESC_NONE;
                    if (in_hex) begin
                        slot_next[n[IdxW-1:0]] = mk_data({hex_val(hd), hex_val(b)}, vs);
                        n = n + CountW'(1);
                    end else begin
                        slot_next[n[IdxW-1:0]] = mk_data(CH_PCT, vs);
                        n = n + CountW'(1);
                        slot_next[n[IdxW-1:0]] = mk_data(hd, vs);
                        n = n + CountW'(1);
                        do_plain = 1'b1;
                    end
                end
                default: begin
                    ph = ESC_NONE;
                    do_plain = 1'b1;
                end
            endcase
            if (do_plain) begin
                if (b == CH_AMP) begin
                    slot_next[n[IdxW-1:0]] = mk_mark(vs, !vs, 1'b1, 1'b0);
                    n = n + CountW'(1);
                    vs = 1'b0;
                    po = 1'b0;
                end else if (b == CH_EQ && !vs) begin
                    po = 1'b1;
                    slot_next[n[IdxW-1:0]] = mk_mark(1'b0, 1'b1, 1'b0, 1'b0);
                    n = n + CountW'(1);
                    vs = 1'b1;
                end else if (b == CH_PCT) begin
                    po = 1'b1;
                    ph = ESC_PCT;
                end else begin
                    po = 1'b1;
                    slot_next[n[IdxW-1:0]] = mk_data((b == CH_PLUS) ? CH_SPACE : b, vs);
                    n = n + CountW'(1);
                end
            end
        end
        if (b == CH_NUL || s_final_req) begin
            if (ph == ESC_PCT) begin
                slot_next[n[IdxW-1:0]] = mk_data(CH_PCT, vs);
                n = n + CountW'(1);
            end else if (ph == ESC_DIGIT) begin
                slot_next[n[IdxW-1:0]] = mk_data(CH_PCT, vs);
                n = n + CountW'(1);
                slot_next[n[IdxW-1:0]] = mk_data(hd, vs);
                n = n + CountW'(1);
            end
            slot_next[n[IdxW-1:0]] = mk_mark(po ? vs : 1'b0, po && !vs, po, 1'b1);
            n  = n + CountW'(1);
            ph = ESC_NONE;
            vs = 1'b0;
            po = 1'b0;
            hd = CH_NUL;
        end
        esc_next  = ph;
        vs_next   = vs;
        po_next   = po;
        held_next = hd;
        cnt_next  = n;
    end

    assign m_valid = (cnt_reg != '0);
    assign at_last = ({1'b0, idx_reg} + CountW'(1)) == cnt_reg;
    assign m_fire  = m_valid && m_ready;
    assign s_ready = !m_valid || (m_fire && at_last);
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg  <= ESC_NONE;
            held_reg <= CH_NUL;
            vs_reg   <= 1'b0;
            po_reg   <= 1'b0;
            cnt_reg  <= '0;
            idx_reg  <= '0;
        end else if (s_fire) begin
            esc_reg  <= esc_next;
            held_reg <= held_next;
            vs_reg   <= vs_next;
            po_reg   <= po_next;
            cnt_reg  <= cnt_next;
            idx_reg  <= '0;
        end else if (m_fire) begin
            if (at_last) begin
                cnt_reg <= '0;
                idx_reg <= '0;
            end else begin
                idx_reg <= idx_reg + IdxW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int i = 0; i < MaxResults; i++) begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

    assign cur             = slot_reg[idx_reg];
    assign m_data_byte     = cur.data_byte;
    assign m_has_data      = cur.has_data;
    assign m_in_value_part = cur.in_value_part;
    assign m_name_end      = cur.name_end;
    assign m_pair_end      = cur.pair_end;
    assign m_query_end     = cur.query_end;
    assign m_last          = at_last;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CountW'(MaxResults))
        else $error("result count out of range");

    a_idx_below_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, idx_reg} < cnt_reg))
        else $error("result index past count");

    a_qend_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_query_end) |-> m_last)
        else $error("query end marker is not the last result");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_query_byte == CH_NUL || s_final_req)) |=>
            (esc_reg == ESC_NONE && !vs_reg && !po_reg && cnt_reg != '0))
        else $error("query end did not clear state");

endmodule
